>>> rtl/quaternion_to_euler_angles_macros.svh
// Assertion macros shared by the quaternion to Euler angle block.
// Included by the top level, which checks its own logic; needs nothing else.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is high.
`define Q2E_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("q2e check failed");

// Implication checked in the following cycle, also active during reset.
`define Q2E_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("q2e check failed");

`endif

>>> rtl/q2e_pkg.sv
// Shared widths, types and the arctangent table for the quaternion to
// Euler angle pipeline. Depends on nothing.
package q2e_pkg;

  localparam int OPW = 34;          // atan2 operand width
  localparam int PAW = 32;          // clamped asin argument width, holds +2^30
  localparam int IW = 62;           // square root work width
  localparam int PCW = 31;          // square root result width
  localparam int ISQ_STEPS = 31;    // one result bit per stage
  localparam int CW = 46;           // CORDIC vector width
  localparam int AW = 34;           // CORDIC angle width, 2^31 is pi
  localparam int RW = 18;           // rounded angle width
  localparam int NORM_STEPS = 6;    // shifts of 32, 16, 8, 4, 2, 1
  localparam int NORM_TOP = 40;     // vector is scaled until this bit is set
  localparam int ANG_TAB_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [OPW-1:0] ONE_Q30 = OPW'(64'sd1073741824);
  localparam logic [IW-1:0] ONE_Q60 = IW'(1) << 60;
  localparam logic signed [AW-1:0] HALF_PI_ANG = AW'(64'sd1073741824);
  localparam logic signed [RW-1:0] PITCH_LIM = RW'(16384);

  typedef struct packed {
    logic signed [OPW-1:0] rn;
    logic signed [OPW-1:0] rd;
    logic signed [OPW-1:0] yn;
    logic signed [OPW-1:0] yd;
    logic signed [PAW-1:0] pa;
    logic                  clamped;
  } pass_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
    logic                 tag;
  } cst_t;

  // atan(2^-i) with 2^31 standing for pi.
  function automatic logic signed [AW-1:0] atan_ang(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = AW'(536870912);
      1: r = AW'(316933406);
      2: r = AW'(167458907);
      3: r = AW'(85004756);
      4: r = AW'(42667331);
      5: r = AW'(21354465);
      6: r = AW'(10679838);
      7: r = AW'(5340245);
      8: r = AW'(2670163);
      9: r = AW'(1335087);
      10: r = AW'(667544);
      11: r = AW'(333772);
      12: r = AW'(166886);
      13: r = AW'(83443);
      14: r = AW'(41722);
      15: r = AW'(20861);
      16: r = AW'(10430);
      17: r = AW'(5215);
      18: r = AW'(2608);
      19: r = AW'(1304);
      20: r = AW'(652);
      21: r = AW'(326);
      22: r = AW'(163);
      23: r = AW'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/q2e_front.sv
// Front end: quaternion products, angle operands, asin clamp and the
// radicand 1 - t^2 in four stages. Uses q2e_pkg.
module q2e_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [15:0]      quat_w,
  input  logic signed [15:0]      quat_x,
  input  logic signed [15:0]      quat_y,
  input  logic signed [15:0]      quat_z,
  output logic                    fo_valid,
  output q2e_pkg::pass_t          fo_pass,
  output logic [q2e_pkg::IW-1:0]  fo_n
);

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic v1, v2, v3;
  q2e_pkg::pass_t s2, s3;
  logic [q2e_pkg::IW-1:0] sq;

  logic signed [q2e_pkg::OPW-1:0] pa_c;
  logic signed [2*q2e_pkg::PAW-1:0] sq_c;
  q2e_pkg::pass_t s2_next;

  always_comb begin
    s2_next.rn = (q2e_pkg::OPW'(p_wx) + q2e_pkg::OPW'(p_yz)) <<< 1;
    s2_next.rd = q2e_pkg::ONE_Q30 - ((q2e_pkg::OPW'(p_xx) + q2e_pkg::OPW'(p_yy)) <<< 1);
    s2_next.yn = (q2e_pkg::OPW'(p_wz) + q2e_pkg::OPW'(p_xy)) <<< 1;
    s2_next.yd = q2e_pkg::ONE_Q30 - ((q2e_pkg::OPW'(p_yy) + q2e_pkg::OPW'(p_zz)) <<< 1);
    pa_c = (q2e_pkg::OPW'(p_wy) - q2e_pkg::OPW'(p_zx)) <<< 1;
    s2_next.clamped = 1'b0;
    if (pa_c > q2e_pkg::ONE_Q30) begin
      pa_c = q2e_pkg::ONE_Q30;
      s2_next.clamped = 1'b1;
    end else if (pa_c < -q2e_pkg::ONE_Q30) begin
      pa_c = -q2e_pkg::ONE_Q30;
      s2_next.clamped = 1'b1;
    end
    s2_next.pa = q2e_pkg::PAW'(pa_c);
    sq_c = (2*q2e_pkg::PAW)'(s2.pa) * (2*q2e_pkg::PAW)'(s2.pa);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      fo_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      fo_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= 32'(quat_w) * 32'(quat_x);
      p_yz <= 32'(quat_y) * 32'(quat_z);
      p_xx <= 32'(quat_x) * 32'(quat_x);
      p_yy <= 32'(quat_y) * 32'(quat_y);
      p_zz <= 32'(quat_z) * 32'(quat_z);
      p_wy <= 32'(quat_w) * 32'(quat_y);
      p_zx <= 32'(quat_z) * 32'(quat_x);
      p_wz <= 32'(quat_w) * 32'(quat_z);
      p_xy <= 32'(quat_x) * 32'(quat_y);
      s2 <= s2_next;
      s3 <= s2;
      sq <= q2e_pkg::IW'($unsigned(sq_c));
      fo_pass <= s3;
      fo_n <= q2e_pkg::ONE_Q60 - sq;
    end
  end

endmodule

>>> rtl/q2e_isqrt.sv
// Pipelined floor square root, one result bit per stage, carrying the
// other operands alongside. Uses q2e_pkg.
module q2e_isqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    si_valid,
  input  q2e_pkg::pass_t          si_pass,
  input  logic [q2e_pkg::IW-1:0]  si_n,
  output logic                    so_valid,
  output q2e_pkg::pass_t          so_pass,
  output logic [q2e_pkg::PCW-1:0] so_root
);

  localparam int N = q2e_pkg::ISQ_STEPS;

  logic [q2e_pkg::IW-1:0] n_s   [0:N];
  logic [q2e_pkg::IW-1:0] res_s [0:N];
  q2e_pkg::pass_t         pass_s [0:N];
  logic                   v_s   [0:N];

  assign n_s[0] = si_n;
  assign res_s[0] = '0;
  assign pass_s[0] = si_pass;
  assign v_s[0] = si_valid;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [q2e_pkg::IW-1:0] BIT = q2e_pkg::IW'(1) << (2 * (N - 1 - j));
    logic [q2e_pkg::IW-1:0] t;
    assign t = res_s[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pass_s[j+1] <= pass_s[j];
        if (n_s[j] >= t) begin
          n_s[j+1] <= n_s[j] - t;
          res_s[j+1] <= (res_s[j] >> 1) + BIT;
        end else begin
          n_s[j+1] <= n_s[j];
          res_s[j+1] <= res_s[j] >> 1;
        end
      end
    end
  end

  assign so_valid = v_s[N];
  assign so_pass = pass_s[N];
  assign so_root = res_s[N][q2e_pkg::PCW-1:0];

endmodule

>>> rtl/q2e_cordic.sv
// Pipelined atan2: quadrant fold, staged normalizing shift, vectoring
// CORDIC iterations and rounding to a 2^15-per-pi angle. Uses q2e_pkg.
module q2e_cordic #(
  parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           ci_valid,
  input  logic signed [q2e_pkg::OPW-1:0] ci_ny,
  input  logic signed [q2e_pkg::OPW-1:0] ci_dx,
  input  logic                           ci_tag,
  output logic                           co_valid,
  output logic signed [q2e_pkg::RW-1:0]  co_angle,
  output logic                           co_tag
);

  localparam int NS = q2e_pkg::NORM_STEPS;
  localparam int LAST = NS + STEPS;

  q2e_pkg::cst_t        st [0:LAST];
  logic [q2e_pkg::CW-1:0] mag [0:NS];
  logic                 v_s [0:LAST];

  q2e_pkg::cst_t pre_next;
  logic signed [q2e_pkg::CW-1:0] ex, ey;

  always_comb begin
    ex = q2e_pkg::CW'(ci_dx);
    ey = q2e_pkg::CW'(ci_ny);
    pre_next.zero = (ex == '0) && (ey == '0);
    pre_next.tag = ci_tag;
    pre_next.x = ex;
    pre_next.y = ey;
    pre_next.acc = '0;
    if (ex < 0) begin
      if (ey >= 0) begin
        pre_next.x = ey;
        pre_next.y = -ex;
        pre_next.acc = q2e_pkg::HALF_PI_ANG;
      end else begin
        pre_next.x = -ey;
        pre_next.y = ex;
        pre_next.acc = -q2e_pkg::HALF_PI_ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= ci_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= pre_next;
      mag[0] <= $unsigned(pre_next.x < 0 ? -pre_next.x : pre_next.x)
              | $unsigned(pre_next.y < 0 ? -pre_next.y : pre_next.y);
    end
  end

  // Scale up until the larger component has its top bit at NORM_TOP.
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 32 >> k;
    localparam logic [q2e_pkg::CW-1:0] LIM = q2e_pkg::CW'(1) << (q2e_pkg::NORM_TOP + 1 - SH);
    logic go;
    assign go = mag[k] < LIM;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= st[k];
        mag[k+1] <= mag[k];
        if (go) begin
          st[k+1].x <= st[k].x <<< SH;
          st[k+1].y <= st[k].y <<< SH;
          mag[k+1] <= mag[k] << SH;
        end
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [q2e_pkg::AW-1:0] ANG = q2e_pkg::atan_ang(i);
    logic signed [q2e_pkg::CW-1:0] sx, sy;
    assign sx = st[NS+i].x >>> i;
    assign sy = st[NS+i].y >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[NS+i+1] <= 1'b0;
      end else if (en) begin
        v_s[NS+i+1] <= v_s[NS+i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[NS+i+1] <= st[NS+i];
        if (st[NS+i].y > 0) begin
          st[NS+i+1].x <= st[NS+i].x + sy;
          st[NS+i+1].y <= st[NS+i].y - sx;
          st[NS+i+1].acc <= st[NS+i].acc + ANG;
        end else begin
          st[NS+i+1].x <= st[NS+i].x - sy;
          st[NS+i+1].y <= st[NS+i].y + sx;
          st[NS+i+1].acc <= st[NS+i].acc - ANG;
        end
      end
    end
  end

  logic signed [q2e_pkg::AW-1:0] rnd;
  assign rnd = (st[LAST].acc + q2e_pkg::AW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      co_valid <= 1'b0;
    end else if (en) begin
      co_valid <= v_s[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_angle <= st[LAST].zero ? '0 : q2e_pkg::RW'(rnd);
      co_tag <= st[LAST].tag;
    end
  end

endmodule

>>> rtl/quaternion_to_euler_angles.sv
// Top level of the quaternion to roll, pitch and yaw converter.
// Uses q2e_pkg, q2e_front, q2e_isqrt, q2e_cordic and the assertion macros.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------------------
//   input   | in        | in_valid/in_stall  | quat_w, quat_x, quat_y, quat_z
//   output  | out       | out_valid/out_stall| roll_angle, pitch_angle, yaw_angle,
//           |           |                    | pitch_clamped
//
// One item enters per cycle while no stalled result holds the pipeline; the depth
// is set by the one-bit-per-stage square root and the CORDIC chain.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled result freezes the whole pipeline in place, input included, so
// nothing is lost or repeated; no new item is taken while the result waits.
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);

  // The pipeline moves whenever the output register can take a new item.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic                           f_valid;
  q2e_pkg::pass_t                 f_pass;
  logic [q2e_pkg::IW-1:0]         f_n;

  q2e_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .fo_valid(f_valid), .fo_pass(f_pass), .fo_n(f_n)
  );

  // The square root gives the cosine leg of the pitch, so asin becomes atan2.
  logic                           r_valid;
  q2e_pkg::pass_t                 r_pass;
  logic [q2e_pkg::PCW-1:0]        r_root;

  q2e_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .si_valid(f_valid), .si_pass(f_pass),
    .si_n(f_n), .so_valid(r_valid), .so_pass(r_pass), .so_root(r_root)
  );

  logic signed [q2e_pkg::OPW-1:0] pitch_ny, pitch_dx;
  assign pitch_ny = q2e_pkg::OPW'(r_pass.pa);
  assign pitch_dx = signed'(q2e_pkg::OPW'(r_root));

  // Three identical atan2 pipelines run in lockstep; the roll one carries valid
  // and the pitch one carries the clamp flag.
  logic                           c_valid;
  logic signed [q2e_pkg::RW-1:0]  roll_c, pitch_c, yaw_c;
  logic                           clamp_c;

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .rst(rst), .en(en), .ci_valid(r_valid),
    .ci_ny(r_pass.rn), .ci_dx(r_pass.rd), .ci_tag(1'b0),
    .co_valid(c_valid), .co_angle(roll_c), .co_tag()
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .rst(rst), .en(en), .ci_valid(r_valid),
    .ci_ny(pitch_ny), .ci_dx(pitch_dx), .ci_tag(r_pass.clamped),
    .co_valid(), .co_angle(pitch_c), .co_tag(clamp_c)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .rst(rst), .en(en), .ci_valid(r_valid),
    .ci_ny(r_pass.yn), .ci_dx(r_pass.yd), .ci_tag(1'b0),
    .co_valid(), .co_angle(yaw_c), .co_tag()
  );

  // Pitch is held to plus or minus a quarter turn; roll and yaw simply wrap,
  // so a result of exactly pi comes out as minus pi.
  logic signed [q2e_pkg::RW-1:0] pitch_sat;
  always_comb begin
    pitch_sat = pitch_c;
    if (pitch_c > q2e_pkg::PITCH_LIM) begin
      pitch_sat = q2e_pkg::PITCH_LIM;
    end else if (pitch_c < -q2e_pkg::PITCH_LIM) begin
      pitch_sat = -q2e_pkg::PITCH_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle <= roll_c[15:0];
      pitch_angle <= pitch_sat[15:0];
      yaw_angle <= yaw_c[15:0];
      pitch_clamped <= clamp_c;
    end
  end

  `Q2E_ASSERT_NEXT(a_rst_clears_out, clk, rst, !out_valid)
  `Q2E_ASSERT_IMPL(a_pitch_range, clk, rst, out_valid, (pitch_angle <= 16'sd16384) && (pitch_angle >= -16'sd16384))
  `Q2E_ASSERT_IMPL(a_clamp_at_pole, clk, rst, out_valid && pitch_clamped, (pitch_angle >= 16'sd16380) || (pitch_angle <= -16'sd16380))

endmodule
